FILE: rtl/sample_phase_sweep_search_defines.svh
// assertion macros for the phase sweep search block
`ifndef SAMPLE_PHASE_SWEEP_SEARCH_DEFINES_SVH
`define SAMPLE_PHASE_SWEEP_SEARCH_DEFINES_SVH

// property that holds in the same cycle, checked outside reset
`define SSPS_ASSERT_NOW(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ssps assertion failed");

// implication whose consequent is checked in the next cycle
`define SSPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssps assertion failed");

`endif

FILE: rtl/ssps_pkg.sv
// types, constants and helpers shared by the phase sweep search modules
package ssps_pkg;

  localparam int unsigned PhaseW  = 5;
  localparam int unsigned StepW   = 6;
  localparam int unsigned SampleW = 5;
  localparam int unsigned BadW    = 5;
  localparam int unsigned ScoreW  = 6;
  localparam int unsigned LineW   = 16;
  localparam int unsigned ExpW    = 12;
  localparam int unsigned OvsW    = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [PhaseW-1:0] MidField   = 5'd16;
  localparam logic [PhaseW-1:0] HalfSample = 5'd16;
  localparam logic [StepW-1:0]  GoodEnough = 6'd17;
  localparam logic [ScoreW-1:0] ScoreMax   = 6'd63;
  localparam logic [OvsW-1:0]   OvsHalf    = 3'd4;

  localparam logic CmdStart   = 1'b0;
  localparam logic CmdMeasure = 1'b1;
  localparam logic KindStep   = 1'b0;
  localparam logic KindFinal  = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EXPECTED    = 2'd0,
    CFG_OVERSAMPLE  = 2'd1,
    CFG_SWEEP_EN    = 2'd2,
    CFG_HALF_AT_TWO = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic             cmd;
    logic [LineW-1:0] line_count;
  } in_word_t;

  typedef struct packed {
    logic              kind;
    logic [PhaseW-1:0] sync_phase;
    logic [PhaseW-1:0] adc_phase;
    logic              success;
  } out_word_t;

  typedef struct packed {
    logic [ExpW-1:0] expected_line_count;
    logic [OvsW-1:0] oversample_ratio;
    logic            sweep_enable;
    logic            half_sample_at_two;
  } cfg_t;

  // classified word as it sits in the queue
  typedef struct packed {
    logic is_start;
    logic bad;
  } cls_t;

  typedef struct packed {
    logic push;
    cls_t entry;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    cls_t entry;
  } q_rd_t;

  typedef struct packed {
    logic             busy;
    logic             emit;
    logic             emit_final;
    logic [StepW-1:0] step_count;
  } back_st_t;

  function automatic logic [PhaseW-1:0] half_sample(input logic [PhaseW-1:0] p);
    return p + HalfSample;
  endfunction

endpackage

FILE: rtl/sample_phase_sweep_search.sv
// phase sweep search: one word per cycle while the output is not stalled; a result
// passes the queue and the result register. a word is classified at the input, held in a
// two-entry queue and handled by the back part; the result register parts the output side.
// throughput is one word per cycle while the output is not stalled.
// reset (async, active low) clears config, queue and sweep state to their
// reset values at once; no clearing pass.
`include "sample_phase_sweep_search_defines.svh"

module sample_phase_sweep_search #(
  parameter int unsigned SWEEP_STEPS       = 34,
  parameter int unsigned SAMPLES_PER_PHASE = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ssps_pkg::in_word_t             in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ssps_pkg::out_word_t            out_word_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ssps_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ssps_pkg::ExpW-1:0]      cfg_data_i
);

  localparam logic [ssps_pkg::StepW-1:0] SweepLast = ssps_pkg::StepW'(SWEEP_STEPS);

  ssps_pkg::cfg_t     cfg_q, cfg_d;
  ssps_pkg::q_wr_t    q_wr;
  ssps_pkg::q_rd_t    q_rd;
  ssps_pkg::back_st_t bk_st;
  logic               q_full;
  logic               pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (ssps_pkg::cfg_idx_e'(cfg_index_i))
        ssps_pkg::CFG_EXPECTED:    cfg_d.expected_line_count = cfg_data_i;
        ssps_pkg::CFG_OVERSAMPLE:  cfg_d.oversample_ratio = cfg_data_i[ssps_pkg::OvsW-1:0];
        ssps_pkg::CFG_SWEEP_EN:    cfg_d.sweep_enable = cfg_data_i[0];
        ssps_pkg::CFG_HALF_AT_TWO: cfg_d.half_sample_at_two = cfg_data_i[0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_line_count <= '0;
      cfg_q.oversample_ratio    <= 3'd1;
      cfg_q.sweep_enable        <= 1'b1;
      cfg_q.half_sample_at_two  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ssps_front u_front (
    .in_valid_i            (in_valid_i),
    .in_word_i             (in_word_i),
    .q_full_i              (q_full),
    .expected_line_count_i (cfg_q.expected_line_count),
    .in_stall_o            (in_stall_o),
    .q_wr_o                (q_wr)
  );

  ssps_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_wr_i (q_wr),
    .pop_i  (pop),
    .q_rd_o (q_rd),
    .full_o (q_full)
  );

  ssps_back #(
    .SWEEP_STEPS       (SWEEP_STEPS),
    .SAMPLES_PER_PHASE (SAMPLES_PER_PHASE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_rd_i      (q_rd),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .st_o        (bk_st)
  );

  // a final answer always ends the sweep
  `SSPS_ASSERT_NEXT(a_final_ends_sweep, clk_i, rst_ni, bk_st.emit_final, !bk_st.busy)
  // a step result leaves the sweep running
  `SSPS_ASSERT_NEXT(a_step_keeps_busy, clk_i, rst_ni, bk_st.emit && !bk_st.emit_final, bk_st.busy)
  // the step counter never reaches the sweep length while sweeping
  `SSPS_ASSERT_NOW(a_step_in_range, clk_i, rst_ni, !bk_st.busy || (bk_st.step_count < SweepLast))

endmodule

FILE: rtl/ssps_front.sv
// front part: accepts input words and classifies them for the back part
module ssps_front (
  input  logic                         in_valid_i,
  input  ssps_pkg::in_word_t           in_word_i,
  input  logic                         q_full_i,
  input  logic [ssps_pkg::ExpW-1:0]    expected_line_count_i,
  output logic                         in_stall_o,
  output ssps_pkg::q_wr_t              q_wr_o
);

  assign in_stall_o = q_full_i;

  always_comb begin
    q_wr_o.push           = in_valid_i && !q_full_i;
    q_wr_o.entry.is_start = (in_word_i.cmd == ssps_pkg::CmdStart);
    // counts above the register width can never match
    q_wr_o.entry.bad      = (in_word_i.line_count !=
                             {{(ssps_pkg::LineW - ssps_pkg::ExpW){1'b0}}, expected_line_count_i});
  end

endmodule

FILE: rtl/ssps_queue.sv
// two-entry queue between the front and back parts
module ssps_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ssps_pkg::q_wr_t q_wr_i,
  input  logic            pop_i,
  output ssps_pkg::q_rd_t q_rd_o,
  output logic            full_o
);

  ssps_pkg::cls_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           do_pop;

  assign do_pop = pop_i && (count_q != 2'd0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (q_wr_i.push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (do_pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({q_wr_i.push, do_pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_wr_i.push) begin
      mem_q[wr_ptr_q] <= q_wr_i.entry;
    end
  end

  assign q_rd_o.valid = (count_q != 2'd0);
  assign q_rd_o.entry = mem_q[rd_ptr_q];
  assign full_o       = (count_q == 2'd2);

endmodule

FILE: rtl/ssps_back.sv
// back part: runs the sweep state and drives the result register
module ssps_back #(
  parameter int unsigned SWEEP_STEPS       = 34,
  parameter int unsigned SAMPLES_PER_PHASE = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ssps_pkg::cfg_t      cfg_i,
  input  ssps_pkg::q_rd_t     q_rd_i,
  output logic                pop_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output ssps_pkg::out_word_t out_word_o,
  output ssps_pkg::back_st_t  st_o
);

  localparam logic [ssps_pkg::StepW-1:0]   SweepLast = ssps_pkg::StepW'(SWEEP_STEPS);
  localparam logic [ssps_pkg::SampleW-1:0] SampleLast = ssps_pkg::SampleW'(SAMPLES_PER_PHASE);

  logic [ssps_pkg::PhaseW-1:0]  sync_q, sync_d;
  logic [ssps_pkg::PhaseW-1:0]  adc_q, adc_d;
  logic                         busy_q, busy_d;
  logic [ssps_pkg::StepW-1:0]   step_q, step_d;
  logic [ssps_pkg::SampleW-1:0] sample_q, sample_d;
  logic [ssps_pkg::BadW-1:0]    bad_now_q, bad_now_d;
  logic [ssps_pkg::BadW-1:0]    bad_prev_q, bad_prev_d;
  logic [ssps_pkg::BadW-1:0]    bad_prev2_q, bad_prev2_d;
  logic [ssps_pkg::ScoreW-1:0]  worst_score_q, worst_score_d;
  logic [ssps_pkg::PhaseW-1:0]  worst_phase_q, worst_phase_d;
  logic [ssps_pkg::StepW-1:0]   clean_q, clean_d;
  logic                         out_valid_q, out_valid_d;
  ssps_pkg::out_word_t          out_word_q, out_word_d;

  logic                         out_free;
  logic                         emit, emit_final, ok;
  logic [ssps_pkg::BadW-1:0]    bad_n;
  logic [ssps_pkg::SampleW-1:0] sample_n;
  logic [ssps_pkg::StepW-1:0]   step_n;
  logic [ssps_pkg::ScoreW:0]    win_sum;
  logic [ssps_pkg::ScoreW-1:0]  win;
  logic                         ovs_half;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = q_rd_i.valid && out_free;
  assign ovs_half = (cfg_i.oversample_ratio == ssps_pkg::OvsHalf);

  always_comb begin
    sync_d        = sync_q;
    adc_d         = adc_q;
    busy_d        = busy_q;
    step_d        = step_q;
    sample_d      = sample_q;
    bad_now_d     = bad_now_q;
    bad_prev_d    = bad_prev_q;
    bad_prev2_d   = bad_prev2_q;
    worst_score_d = worst_score_q;
    worst_phase_d = worst_phase_q;
    clean_d       = clean_q;
    emit          = 1'b0;
    emit_final    = 1'b0;
    ok            = 1'b0;
    bad_n         = bad_now_q + ssps_pkg::BadW'(q_rd_i.entry.bad);
    sample_n      = sample_q + 1'b1;
    step_n        = step_q + 1'b1;
    win_sum       = (ssps_pkg::ScoreW+1)'(bad_n) + (ssps_pkg::ScoreW+1)'(bad_prev_q)
                    + (ssps_pkg::ScoreW+1)'(bad_prev2_q);
    win           = (win_sum > (ssps_pkg::ScoreW+1)'(ssps_pkg::ScoreMax))
                    ? ssps_pkg::ScoreMax : win_sum[ssps_pkg::ScoreW-1:0];

    if (pop_o) begin
      if (q_rd_i.entry.is_start) begin
        if (!busy_q) begin
          if (!cfg_i.sweep_enable) begin
            sync_d     = ssps_pkg::MidField;
            adc_d      = ovs_half ? ssps_pkg::half_sample(ssps_pkg::MidField)
                                  : ssps_pkg::MidField;
            emit       = 1'b1;
            emit_final = 1'b1;
            ok         = 1'b1;
          end else begin
            busy_d        = 1'b1;
            step_d        = '0;
            bad_prev_d    = '0;
            bad_prev2_d   = '0;
            worst_score_d = '0;
            worst_phase_d = '0;
            clean_d       = '0;
            sync_d        = sync_q + 1'b1;
            bad_now_d     = '0;
            sample_d      = '0;
            emit          = 1'b1;
          end
        end
      end else if (busy_q) begin
        bad_now_d = bad_n;
        sample_d  = sample_n;
        if (sample_n >= SampleLast) begin
          // end of one phase step: score the three-step window
          if (win > worst_score_q) begin
            worst_score_d = win;
            worst_phase_d = sync_q - 1'b1;
          end
          if (bad_n == '0) begin
            clean_d = clean_q + 1'b1;
          end
          bad_prev2_d = bad_prev_q;
          bad_prev_d  = bad_n;
          step_d      = step_n;
          emit        = 1'b1;
          if (step_n < SweepLast) begin
            sync_d    = sync_q + 1'b1;
            bad_now_d = '0;
            sample_d  = '0;
          end else begin
            busy_d     = 1'b0;
            sample_d   = '0;
            emit_final = 1'b1;
            if (clean_d >= ssps_pkg::GoodEnough) begin
              ok = 1'b1;
              if (worst_score_d != '0) begin
                sync_d = ssps_pkg::half_sample(worst_phase_d);
                adc_d  = (ovs_half || cfg_i.half_sample_at_two)
                         ? ssps_pkg::half_sample(ssps_pkg::MidField) : ssps_pkg::MidField;
              end else begin
                sync_d = ssps_pkg::MidField;
                adc_d  = ovs_half ? ssps_pkg::half_sample(ssps_pkg::MidField)
                                  : ssps_pkg::MidField;
              end
            end
          end
        end
      end
    end

    out_valid_d = emit ? 1'b1 : (out_valid_q && out_stall_i);
    out_word_d  = out_word_q;
    if (emit) begin
      out_word_d.kind       = emit_final ? ssps_pkg::KindFinal : ssps_pkg::KindStep;
      out_word_d.sync_phase = sync_d;
      out_word_d.adc_phase  = adc_d;
      out_word_d.success    = ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q        <= ssps_pkg::MidField;
      adc_q         <= ssps_pkg::MidField;
      busy_q        <= 1'b0;
      step_q        <= '0;
      sample_q      <= '0;
      bad_now_q     <= '0;
      bad_prev_q    <= '0;
      bad_prev2_q   <= '0;
      worst_score_q <= '0;
      worst_phase_q <= '0;
      clean_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      sync_q        <= sync_d;
      adc_q         <= adc_d;
      busy_q        <= busy_d;
      step_q        <= step_d;
      sample_q      <= sample_d;
      bad_now_q     <= bad_now_d;
      bad_prev_q    <= bad_prev_d;
      bad_prev2_q   <= bad_prev2_d;
      worst_score_q <= worst_score_d;
      worst_phase_q <= worst_phase_d;
      clean_q       <= clean_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_comb begin
    st_o.busy       = busy_q;
    st_o.emit       = emit;
    st_o.emit_final = emit_final;
    st_o.step_count = step_q;
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the sampling phase sweep search block
module testbench;

  localparam int SweepSteps     = 34;
  localparam int SamplesPerStep = 20;
  localparam int LongHold       = 300;
  localparam int LimitCycles    = 3000;

  typedef enum int {SWEEP_BAND, SWEEP_FAIL, SWEEP_CLEAN} sweep_kind_e;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_stall_o;
  ssps_pkg::in_word_t             in_word_i   = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  ssps_pkg::out_word_t            out_word_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [ssps_pkg::CfgIdxW-1:0]   cfg_index_i = '0;
  logic [ssps_pkg::ExpW-1:0]      cfg_data_i  = '0;

  // register shadow
  logic [ssps_pkg::ExpW-1:0]   exp_len   = '0;
  logic [ssps_pkg::OvsW-1:0]   ovs       = 3'd1;
  logic                        sweep_on  = 1'b1;
  logic                        half_two  = 1'b0;

  // sweep state as the block should hold it
  logic [ssps_pkg::PhaseW-1:0]  sync_ph       = ssps_pkg::MidField;
  logic [ssps_pkg::PhaseW-1:0]  adc_ph        = ssps_pkg::MidField;
  logic                         sweeping      = 1'b0;
  logic [ssps_pkg::StepW-1:0]   steps_done    = '0;
  logic [ssps_pkg::SampleW-1:0] samples_taken = '0;
  logic [ssps_pkg::BadW-1:0]    bad_cur       = '0;
  logic [ssps_pkg::BadW-1:0]    bad_p1        = '0;
  logic [ssps_pkg::BadW-1:0]    bad_p2        = '0;
  logic [ssps_pkg::ScoreW-1:0]  worst         = '0;
  logic [ssps_pkg::PhaseW-1:0]  worst_ph      = '0;
  logic [ssps_pkg::StepW-1:0]   clean_cnt     = '0;

  ssps_pkg::in_word_t  pending_words[$];
  ssps_pkg::out_word_t due_answers[$];
  ssps_pkg::out_word_t want;
  int        words_queued  = 0;
  int        words_taken   = 0;
  int        n_errors      = 0;
  int        quiet_cycles  = 0;
  logic      word_taken    = 1'b0;
  int        in_gap_pct    = 30;
  int        out_stall_pct = 30;
  int        in_gap_left   = 0;
  int        stall_left    = 0;
  int        hold_left     = 0;
  int        holds_asked   = 0;
  int        holds_done    = 0;

  sample_phase_sweep_search #(
    .SWEEP_STEPS      (SweepSteps),
    .SAMPLES_PER_PHASE(SamplesPerStep)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void post_answer(input logic kind, input logic ok);
    due_answers.push_back('{kind: kind, sync_phase: sync_ph, adc_phase: adc_ph, success: ok});
  endfunction

  function automatic void mid_defaults();
    sync_ph = ssps_pkg::MidField;
    adc_ph  = (ovs == ssps_pkg::OvsHalf) ? ssps_pkg::MidField + ssps_pkg::HalfSample
                                         : ssps_pkg::MidField;
  endfunction

  function automatic void next_phase();
    sync_ph       = sync_ph + 5'd1;
    bad_cur       = '0;
    samples_taken = '0;
  endfunction

  // advances the sweep by one accepted word and queues any answer it causes
  function automatic void phase_search_step(input ssps_pkg::in_word_t w);
    logic [6:0] window;
    if (w.cmd == ssps_pkg::CmdStart) begin
      if (sweeping) return;
      if (!sweep_on) begin
        mid_defaults();
        post_answer(ssps_pkg::KindFinal, 1'b1);
        return;
      end
      sweeping   = 1'b1;
      steps_done = '0;
      bad_p1     = '0;
      bad_p2     = '0;
      worst      = '0;
      worst_ph   = '0;
      clean_cnt  = '0;
      next_phase();
      post_answer(ssps_pkg::KindStep, 1'b0);
      return;
    end
    if (!sweeping) return;
    if (w.line_count != {4'b0, exp_len}) bad_cur = bad_cur + 5'd1;
    samples_taken = samples_taken + 5'd1;
    if (samples_taken < SamplesPerStep) return;

    window = bad_cur + bad_p1 + bad_p2;
    if (window > ssps_pkg::ScoreMax) window = ssps_pkg::ScoreMax;
    // centre of the window is the step before the current one
    if (window[ssps_pkg::ScoreW-1:0] > worst) begin
      worst    = window[ssps_pkg::ScoreW-1:0];
      worst_ph = sync_ph - 5'd1;
    end
    if (bad_cur == '0) clean_cnt = clean_cnt + 6'd1;
    bad_p2     = bad_p1;
    bad_p1     = bad_cur;
    steps_done = steps_done + 6'd1;
    if (steps_done < SweepSteps) begin
      next_phase();
      post_answer(ssps_pkg::KindStep, 1'b0);
      return;
    end

    sweeping      = 1'b0;
    samples_taken = '0;
    if (clean_cnt < ssps_pkg::GoodEnough) begin
      post_answer(ssps_pkg::KindFinal, 1'b0);
      return;
    end
    if (worst != '0) begin
      sync_ph = worst_ph + ssps_pkg::HalfSample;
      adc_ph  = (ovs == ssps_pkg::OvsHalf || half_two)
                ? ssps_pkg::MidField + ssps_pkg::HalfSample : ssps_pkg::MidField;
    end else begin
      mid_defaults();
    end
    post_answer(ssps_pkg::KindFinal, 1'b1);
  endfunction

  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 8);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [ssps_pkg::LineW-1:0] bad_line(
      input logic [ssps_pkg::ExpW-1:0] good);
    case ($urandom_range(2))
      0: return 16'($urandom);
      1: return {4'b0, good} ^ (16'd1 << $urandom_range(15));
      default: return {4'($urandom_range(15, 1)), good};
    endcase
  endfunction

  function automatic logic [ssps_pkg::OvsW-1:0] pick_ovs();
    return $urandom_range(1) ? ssps_pkg::OvsHalf : 3'($urandom_range(7));
  endfunction

  // sender
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || word_taken) begin
      if (in_gap_left != 0) begin
        in_valid_i  <= 1'b0;
        in_gap_left <= in_gap_left - 1;
      end else if (pending_words.size() != 0) begin
        in_word_i   <= pending_words.pop_front();
        in_valid_i  <= 1'b1;
        in_gap_left <= pick_gap(in_gap_pct);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (holds_done != holds_asked) begin
      out_stall_i <= 1'b1;
      hold_left   <= LongHold;
      holds_done  <= holds_asked;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left  <= pick_gap(out_stall_pct);
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk_i) begin
    word_taken <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        phase_search_step(in_word_i);
        words_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (due_answers.size() == 0) begin
          $error("result with nothing due: kind %0d sync %0d adc %0d success %0d",
                 out_word_o.kind, out_word_o.sync_phase, out_word_o.adc_phase,
                 out_word_o.success);
          n_errors++;
        end else begin
          want = due_answers.pop_front();
          if (out_word_o.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_word_o.kind);
            n_errors++;
          end
          if (out_word_o.sync_phase !== want.sync_phase) begin
            $error("sync_phase: expected %0d, got %0d", want.sync_phase,
                   out_word_o.sync_phase);
            n_errors++;
          end
          if (out_word_o.adc_phase !== want.adc_phase) begin
            $error("adc_phase: expected %0d, got %0d", want.adc_phase,
                   out_word_o.adc_phase);
            n_errors++;
          end
          if (out_word_o.success !== want.success) begin
            $error("success: expected %0d, got %0d", want.success, out_word_o.success);
            n_errors++;
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= LimitCycles) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  task automatic offer(input logic cmd, input logic [ssps_pkg::LineW-1:0] cnt);
    pending_words.push_back('{cmd: cmd, line_count: cnt});
    words_queued++;
  endtask

  // wait for the sender to empty and every answer to come back, then let the pipe drain
  task automatic settle();
    while (words_taken != words_queued || due_answers.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic cfg_put(input ssps_pkg::cfg_idx_e idx,
                         input logic [ssps_pkg::ExpW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      ssps_pkg::CFG_EXPECTED:   exp_len  = data;
      ssps_pkg::CFG_OVERSAMPLE: ovs      = data[ssps_pkg::OvsW-1:0];
      ssps_pkg::CFG_SWEEP_EN:   sweep_on = data[0];
      default:                  half_two = data[0];
    endcase
    @(negedge clk_i);
  endtask

  task automatic write_regs(input logic [ssps_pkg::ExpW-1:0] exp_v,
                            input logic [ssps_pkg::OvsW-1:0] ovs_v,
                            input logic en_v, input logic half_v);
    cfg_put(ssps_pkg::CFG_EXPECTED, exp_v);
    cfg_put(ssps_pkg::CFG_OVERSAMPLE, {9'b0, ovs_v});
    cfg_put(ssps_pkg::CFG_SWEEP_EN, {11'b0, en_v});
    cfg_put(ssps_pkg::CFG_HALF_AT_TWO, {11'b0, half_v});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_sweep(input sweep_kind_e flavour);
    int band_lo;
    int band_len;
    int n_bad;
    band_lo  = $urandom_range(SweepSteps - 1);
    band_len = $urandom_range(12, 1);
    offer(ssps_pkg::CmdStart, 16'($urandom));
    for (int s = 0; s < SweepSteps; s++) begin
      case (flavour)
        SWEEP_BAND:
          n_bad = (s >= band_lo && s < band_lo + band_len) ?
                  $urandom_range(SamplesPerStep, 1) : 0;
        SWEEP_FAIL:
          n_bad = ($urandom_range(99) < 80) ? $urandom_range(SamplesPerStep, 1) : 0;
        default:
          n_bad = 0;
      endcase
      for (int j = 0; j < SamplesPerStep; j++) begin
        // a start in mid sweep must be ignored
        if ($urandom_range(49) == 0) offer(ssps_pkg::CmdStart, 16'($urandom));
        if ($urandom_range(SamplesPerStep - 1) < n_bad) begin
          offer(ssps_pkg::CmdMeasure, bad_line(exp_len));
        end else begin
          offer(ssps_pkg::CmdMeasure, {4'b0, exp_len});
        end
      end
    end
  endtask

  // loose words with sweep off: every start answers at once
  task automatic queue_loose(input int n, input int start_pct);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < start_pct) offer(ssps_pkg::CmdStart, 16'($urandom));
      else offer(ssps_pkg::CmdMeasure, 16'($urandom));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // measurements while idle are dropped
    settle();
    offer(ssps_pkg::CmdMeasure, 16'hFFFF);
    offer(ssps_pkg::CmdMeasure, 16'h0000);

    // sweep off: defaults under several oversample ratios
    for (int k = 0; k < 4; k++) begin
      settle();
      write_regs(k[0] ? 12'hFFF : 12'h000, (k == 0) ? ssps_pkg::OvsHalf : 3'(7 * k - 7),
                 1'b0, k[1]);
      offer(ssps_pkg::CmdStart, 16'hFFFF);
      offer(ssps_pkg::CmdMeasure, 16'($urandom));
      offer(ssps_pkg::CmdStart, 16'h0000);
    end

    settle();
    write_regs(12'h000, pick_ovs(), 1'b1, 1'($urandom));
    in_gap_pct    = 30;
    out_stall_pct = 30;
    holds_asked++;
    queue_sweep(SWEEP_BAND);

    // long receiver hold while starts keep coming, so the block backs up
    settle();
    write_regs(12'($urandom), pick_ovs(), 1'b0, 1'($urandom));
    in_gap_pct = 0;
    holds_asked++;
    queue_loose(40, 85);

    settle();
    write_regs(12'hFFF, pick_ovs(), 1'b1, 1'($urandom));
    in_gap_pct    = 50;
    out_stall_pct = 20;
    queue_sweep(SWEEP_FAIL);

    settle();
    write_regs(12'($urandom), pick_ovs(), 1'b0, 1'($urandom));
    in_gap_pct    = 20;
    out_stall_pct = 50;
    queue_loose(30, 50);

    settle();
    write_regs(12'($urandom), pick_ovs(), 1'b1, 1'($urandom));
    in_gap_pct    = 0;
    out_stall_pct = 0;
    queue_sweep(SWEEP_CLEAN);

    settle();
    repeat (10) @(negedge clk_i);
    if (n_errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

FILE: sample_phase_sweep_search.f
+incdir+rtl
rtl/ssps_pkg.sv
rtl/ssps_front.sv
rtl/ssps_queue.sv
rtl/ssps_back.sv
rtl/sample_phase_sweep_search.sv
test/testbench.sv
